FILE: rtl/dbc_pkg.sv
package dbc_pkg;

   localparam int Rounds        = 16;
   localparam int HalfKeyBits   = 28;
   localparam int SubkeyBits    = 48;
   localparam int HalfBlockBits = 32;
   localparam int KeyBits       = 64;
   localparam int BlockBits     = 64;
   localparam int CsrAddrBits   = 3;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [CsrAddrBits-1:0] CSR_CIPHER_KEY = 3'd0;

   typedef logic [HalfKeyBits-1:0] half_key_type;

   // state handed from one round cell to the next
   typedef struct packed {
      logic                       vld;
      logic                       dec;
      logic [HalfBlockBits-1:0]   l;
      logic [HalfBlockBits-1:0]   r;
      half_key_type               c;
      half_key_type               d;
   } cell_type;

   localparam logic [7:0] TAB_IP [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

   localparam logic [7:0] TAB_FP [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

   localparam logic [7:0] TAB_E [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
      28,29,30,31,32,1};

   localparam logic [7:0] TAB_P [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

   localparam logic [7:0] TAB_PC1 [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

   localparam logic [7:0] TAB_PC2 [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
      16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
      44,49,39,56,34,53, 46,42,50,36,29,32};

   localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam logic [3:0] TAB_S [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   function automatic logic [63:0] ip_perm(input logic [63:0] x);
      logic [63:0] y;
      for (int k = 0; k < 64; k++) y[63-k] = x[64 - int'(TAB_IP[k])];
      return y;
   endfunction

   function automatic logic [63:0] fp_perm(input logic [63:0] x);
      logic [63:0] y;
      for (int k = 0; k < 64; k++) y[63-k] = x[64 - int'(TAB_FP[k])];
      return y;
   endfunction

   function automatic logic [55:0] pc1_perm(input logic [63:0] x);
      logic [55:0] y;
      for (int k = 0; k < 56; k++) y[55-k] = x[64 - int'(TAB_PC1[k])];
      return y;
   endfunction

   function automatic logic [47:0] pc2_perm(input logic [55:0] x);
      logic [47:0] y;
      for (int k = 0; k < 48; k++) y[47-k] = x[56 - int'(TAB_PC2[k])];
      return y;
   endfunction

   function automatic half_key_type rotl(input half_key_type x, input logic [1:0] s);
      half_key_type y;
      y = (s == 2'd2) ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
      return y;
   endfunction

   function automatic half_key_type rotr(input half_key_type x, input logic [1:0] s);
      half_key_type y;
      y = (s == 2'd2) ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
      return y;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int k2 = 0; k2 < 48; k2++) e[47-k2] = r[32 - int'(TAB_E[k2])];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         six = e[47-6*i -: 6];
         s[31-4*i -: 4] = TAB_S[i][{six[5], six[0], six[4:1]}];
      end
      for (int k3 = 0; k3 < 32; k3++) p[31-k3] = s[32 - int'(TAB_P[k3])];
      return p;
   endfunction

endpackage

FILE: rtl/dbc_round_cell.sv
module dbc_round_cell #(
   parameter int RoundIdx = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  dbc_pkg::cell_type  cell_in,
   output dbc_pkg::cell_type  cell_out
);

   // encrypt rotates left before the subkey; decrypt uses the key of this
   // round in reverse order, reached by rotating right after the subkey
   localparam logic [1:0] EncRot = dbc_pkg::TAB_ROT[RoundIdx];
   localparam logic [1:0] DecRot = dbc_pkg::TAB_ROT[dbc_pkg::Rounds - 1 - RoundIdx];

   dbc_pkg::cell_type      cell_in_ff;
   dbc_pkg::cell_type      cell_out_in;
   dbc_pkg::half_key_type  enc_c;
   dbc_pkg::half_key_type  enc_d;
   dbc_pkg::half_key_type  key_c;
   dbc_pkg::half_key_type  key_d;
   logic [dbc_pkg::SubkeyBits-1:0] subkey;

   always_comb begin
      enc_c = dbc_pkg::rotl(cell_in.c, EncRot);
      enc_d = dbc_pkg::rotl(cell_in.d, EncRot);
      key_c = cell_in.dec ? cell_in.c : enc_c;
      key_d = cell_in.dec ? cell_in.d : enc_d;
      subkey = dbc_pkg::pc2_perm({key_c, key_d});
      cell_out_in     = cell_in;
      cell_out_in.l   = cell_in.r;
      cell_out_in.r   = cell_in.l ^ dbc_pkg::feistel(cell_in.r, subkey);
      cell_out_in.c   = cell_in.dec ? dbc_pkg::rotr(cell_in.c, DecRot) : enc_c;
      cell_out_in.d   = cell_in.dec ? dbc_pkg::rotr(cell_in.d, DecRot) : enc_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_in_ff <= '0;
      end else begin
         cell_in_ff <= cell_out_in;
      end
   end

   assign cell_out = cell_in_ff;

endmodule

FILE: rtl/des_block_cipher_core.sv
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+-------------------------------
// request  | req_cmd, req_block_in               | start & !busy (busy only in reset)
// response | rsp_block_out                       | rsp_valid, one cycle, no stall
// csr      | csr_psel/penable/pwrite/paddr/...   | APB, pready always high
//
// One transaction enters each cycle; busy is high only during reset. The chain
// holds one input register (IP, PC-1), then sixteen round cells, each
// holding one round and one key-schedule step; IP^-1 sits on the output path
// from the last cell. Reset clears the chain and the key register.
// The receiver cannot stall, so the chain never stops.
module des_block_cipher_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [dbc_pkg::BlockBits-1:0] req_block_in,
   output logic                        rsp_valid,
   output logic [dbc_pkg::BlockBits-1:0] rsp_block_out,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dbc_pkg::CsrAddrBits-1:0] csr_paddr,
   input  logic [dbc_pkg::KeyBits-1:0] csr_pwdata,
   output logic [dbc_pkg::KeyBits-1:0] csr_prdata,
   output logic                        csr_pready
);

   logic [dbc_pkg::KeyBits-1:0] key_ff;
   logic [dbc_pkg::KeyBits-1:0] key_in;
   logic                        key_we;
   logic [55:0]                 cd;
   logic [63:0]                 ip_x;
   dbc_pkg::cell_type           head_ff;
   dbc_pkg::cell_type           head_in;
   dbc_pkg::cell_type           chain [dbc_pkg::Rounds+1];

   // nothing is taken while reset holds the chain
   assign busy       = reset;
   assign csr_pready = 1'b1;

   // key register at offset 0; other addresses ignored
   assign key_we = csr_psel & csr_penable & csr_pwrite & csr_pready
                   & (csr_paddr == dbc_pkg::CSR_CIPHER_KEY);
   assign key_in = key_we ? csr_pwdata : key_ff;
   assign csr_prdata = (csr_paddr == dbc_pkg::CSR_CIPHER_KEY) ? key_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // entry: initial permutation and PC-1; for decrypt the halves start at
   // the fully rotated position, which equals the unrotated one (28 total)
   always_comb begin
      cd   = dbc_pkg::pc1_perm(key_ff);
      ip_x = dbc_pkg::ip_perm(req_block_in);
      head_in.vld = start & ~busy;
      head_in.dec = (req_cmd == dbc_pkg::CMD_DECRYPT);
      head_in.l   = ip_x[63:32];
      head_in.r   = ip_x[31:0];
      head_in.c   = cd[55:28];
      head_in.d   = cd[27:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < dbc_pkg::Rounds; g++) begin : g_round
      dbc_round_cell #(.RoundIdx(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // final swap then IP^-1
   assign rsp_valid     = chain[dbc_pkg::Rounds].vld;
   assign rsp_block_out = dbc_pkg::fp_perm({chain[dbc_pkg::Rounds].r,
                                            chain[dbc_pkg::Rounds].l});

endmodule

FILE: rtl/dbc_checker.sv
module dbc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic                        csr_pready
);

   // every accepted transaction returns a response on rsp_valid
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##17 rsp_valid)
      else $error("response missing after accepted transaction");

   // no response without an earlier accepted transaction
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      ##17 rsp_valid |-> $past(start && !busy, 17))
      else $error("response without transaction");

   a_never_busy : assert property (@(posedge clock) disable iff (reset)
      !busy && csr_pready)
      else $error("busy or pready misbehaves");

endmodule

bind des_block_cipher_core dbc_checker u_dbc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .csr_pready (csr_pready)
);

FILE: tb/tb_des_block_cipher_core.sv
`timescale 1ns / 100ps

// DES core testbench: directed key/block corners, then randomized ECB traffic
// with encrypt/decrypt round trips under several keys and idle profiles.
// Every accepted transaction is predicted by a local DES model and the result
// is checked in order against rsp_block_out.
module tb_des_block_cipher_core;
   import dbc_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 30;   // pipeline is 17 deep

   typedef struct packed {
      logic                 cmd;
      logic [BlockBits-1:0] blk;
   } block_req_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_cmd;
   logic [BlockBits-1:0]   req_block_in;
   logic                   rsp_valid;
   logic [BlockBits-1:0]   rsp_block_out;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [KeyBits-1:0]     csr_pwdata;
   logic [KeyBits-1:0]     csr_prdata;
   logic                   csr_pready;

   block_req_type        pending_blocks[$];
   logic [BlockBits-1:0] expected_blocks[$];
   logic [KeyBits-1:0]   key_model;
   int                   idle_pct;
   int                   cycle_count;
   int                   error_count;
   int                   checked_count;
   int                   enc_count;
   int                   dec_count;
   block_req_type        next_req;

   des_block_cipher_core u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_block_out (rsp_block_out),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // Local DES: key schedule, IP, 16 rounds, swap, IP^-1. Bit 1 is the MSB.
   function automatic logic [63:0] des_transform(input logic [63:0] key, input logic dec,
                                                 input logic [63:0] blk);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      logic [47:0] subkey[16];
      logic [47:0] kk;
      logic [47:0] e;
      logic [63:0] x;
      logic [63:0] y;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      int          row;
      int          col;
      for (int k = 0; k < 56; k++) cd[55-k] = key[64 - int'(TAB_PC1[k])];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < Rounds; i++) begin
         if (TAB_ROT[i] == 2'd2) begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
         end else begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         cd = {c, d};
         for (int k = 0; k < 48; k++) subkey[i][47-k] = cd[56 - int'(TAB_PC2[k])];
      end
      for (int k = 0; k < 64; k++) x[63-k] = blk[64 - int'(TAB_IP[k])];
      l = x[63:32];
      r = x[31:0];
      for (int i = 0; i < Rounds; i++) begin
         kk = dec ? subkey[Rounds-1-i] : subkey[i];
         for (int k = 0; k < 48; k++) e[47-k] = r[32 - int'(TAB_E[k])];
         e = e ^ kk;
         for (int b = 0; b < 8; b++) begin
            six = e[47-6*b -: 6];
            row = int'({six[5], six[0]});
            col = int'(six[4:1]);
            s[31-4*b -: 4] = TAB_S[b][row*16 + col];
         end
         for (int k = 0; k < 32; k++) p[31-k] = s[32 - int'(TAB_P[k])];
         t = r;
         r = l ^ p;
         l = t;
      end
      x = {r, l};
      for (int k = 0; k < 64; k++) y[63-k] = x[64 - int'(TAB_FP[k])];
      return y;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Driver: pulls from pending_blocks, random idle per idle_pct. A transaction
   // is taken when start & !busy at the edge; its expected result is queued then.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_blocks.insert(expected_blocks.size(),
                                   des_transform(key_model, req_cmd, req_block_in));
            if (req_cmd == CMD_DECRYPT) dec_count++;
            else enc_count++;
         end
         if (!(start && busy)) begin
            if (pending_blocks.size() > 0 && $urandom_range(99) >= idle_pct) begin
               next_req = pending_blocks.pop_front();
               start <= 1'b1;
               req_cmd <= next_req.cmd;
               req_block_in <= next_req.blk;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: the receiver never stalls, every strobe is one transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result %h (expected none)", $time, rsp_block_out);
            error_count++;
         end else begin
            if (rsp_block_out !== expected_blocks[0]) begin
               $display("%0t: block_out mismatch expected %h actual %h",
                        $time, expected_blocks[0], rsp_block_out);
               error_count++;
            end
            void'(expected_blocks.pop_front());
            checked_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_blocks.size());
         $display("tb_des_block_cipher_core: FAIL");
         $finish;
      end
   end

   // Wait until nothing is queued, in flight or expected, then let the chain empty.
   task automatic wait_drained();
      while (pending_blocks.size() != 0 || start || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // APB write: setup then access; the key lands on the access edge.
   task automatic write_key(input logic [KeyBits-1:0] key);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_CIPHER_KEY;
      csr_pwdata <= key;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      key_model = key;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_block(input logic cmd, input logic [BlockBits-1:0] blk);
      pending_blocks.insert(pending_blocks.size(), '{cmd: cmd, blk: blk});
   endtask

   // Mostly round trips: encrypt a random block, then decrypt its ciphertext.
   task automatic push_random(input int count);
      logic [63:0] blk;
      logic        cmd;
      for (int n = 0; n < count; n++) begin
         blk = {$urandom, $urandom};
         if ($urandom_range(99) < 60) begin
            push_block(CMD_ENCRYPT, blk);
            push_block(CMD_DECRYPT, des_transform(key_model, CMD_ENCRYPT, blk));
            n++;
         end else begin
            cmd = 1'($urandom_range(1));
            push_block(cmd, blk);
         end
      end
   endtask

   initial begin
      logic [63:0] ct;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_ENCRYPT;
      req_block_in = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_CIPHER_KEY;
      csr_pwdata = '0;
      key_model = '0;
      idle_pct = 0;
      cycle_count = 0;
      error_count = 0;
      checked_count = 0;
      enc_count = 0;
      dec_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key (all zero), extreme blocks, both commands.
      push_block(CMD_ENCRYPT, 64'h0);
      push_block(CMD_DECRYPT, 64'h0);
      push_block(CMD_ENCRYPT, '1);
      push_block(CMD_DECRYPT, '1);
      push_block(CMD_ENCRYPT, 64'h8000_0000_0000_0001);

      // Textbook key and block; round trip back to plaintext.
      write_key(64'h1334_5779_9BBC_DFF1);
      push_block(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      push_block(CMD_DECRYPT, 64'h85E8_1354_0F0A_B405);
      push_block(CMD_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
      push_block(CMD_ENCRYPT, 64'h5555_5555_5555_5555);

      // Same key with every parity bit flipped: results must not change.
      write_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
      push_block(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      push_block(CMD_DECRYPT, 64'h85E8_1354_0F0A_B405);

      // All-ones key.
      write_key('1);
      push_block(CMD_ENCRYPT, 64'h0);
      push_block(CMD_ENCRYPT, '1);
      push_block(CMD_DECRYPT, '1);
      ct = des_transform('1, CMD_ENCRYPT, 64'hDEAD_BEEF_0BAD_F00D);
      push_block(CMD_ENCRYPT, 64'hDEAD_BEEF_0BAD_F00D);
      push_block(CMD_DECRYPT, ct);

      // Random traffic: back to back, sender mostly idle, light idle.
      write_key({$urandom, $urandom});
      idle_pct = 0;
      push_random(60);
      // hold-off: let everything come back before resuming
      wait_drained();
      push_random(60);

      write_key({$urandom, $urandom});
      idle_pct = 64;
      push_random(120);

      write_key({$urandom, $urandom});
      idle_pct = 10;
      push_random(120);

      write_key(64'h0);
      idle_pct = 0;
      push_random(70);

      write_key(64'hFEFE_FEFE_FEFE_FEFE);
      idle_pct = 10;
      push_random(70);

      wait_drained();

      $display("covered %0d encrypt and %0d decrypt transactions, %0d results checked",
               enc_count, dec_count, checked_count);
      $display("keys: zero, all ones, parity-only change, textbook and random; idle 0/10/64%%");
      if (error_count == 0 && expected_blocks.size() == 0) begin
         $display("tb_des_block_cipher_core: PASS");
      end else begin
         $display("tb_des_block_cipher_core: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/dbc_pkg.sv
rtl/dbc_round_cell.sv
rtl/des_block_cipher_core.sv
rtl/dbc_checker.sv
tb/tb_des_block_cipher_core.sv
